### rtl/sps_pkg.sv
// Package for the stepper phase sequencer: widths, codes, pattern tables and divider constants.
package sps_pkg;

  // Field widths.
  localparam int AMOUNT_W = 16;
  localparam int CMD_W    = 2;
  localparam int COILS_W  = 4;
  localparam int PHASE_W  = 3;
  localparam int DELAY_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Motor geometry.
  localparam int STEPS_PER_REV = 200;
  localparam int DEG_PER_REV   = 360;

  // Reset values of the configuration registers.
  localparam logic                 STEP_MODE_RST    = 1'b0;
  localparam logic                 INVERT_DRIVE_RST = 1'b0;
  localparam logic [DELAY_W-1:0]   PHASE_DELAY_RST  = 16'd10;

  // Degrees to steps: floor(amount * S / 360) is taken as (amount * M) >> RECIP_SHIFT.
  // With 2**RECIP_SHIFT >= 360 * 2**AMOUNT_W and M rounded up, the result is exact
  // for every amount.
  localparam int    RECIP_SHIFT = AMOUNT_W + $clog2(DEG_PER_REV);
  localparam longint RECIP_FULL =
    ((longint'(1) << RECIP_SHIFT) * STEPS_PER_REV + DEG_PER_REV - 1) / DEG_PER_REV;
  localparam longint RECIP_HALF =
    ((longint'(1) << RECIP_SHIFT) * 2 * STEPS_PER_REV + DEG_PER_REV - 1) / DEG_PER_REV;
  localparam int    RECIP_W = $clog2(RECIP_HALF + 1);
  localparam int    PROD_W  = AMOUNT_W + RECIP_W;

  // Command codes; the fourth code behaves as a time tick.
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_MOVE_COUNT = 2'd1,
    CMD_MOVE_DEG   = 2'd2,
    CMD_TICK_ALT   = 2'd3
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_MODE    = 2'd0,
    REG_INVERT_DRIVE = 2'd1,
    REG_PHASE_DELAY  = 2'd2
  } cfg_reg_t;

  // Coil pattern tables.
  localparam logic [COILS_W-1:0] FULL_TAB [0:3] = '{4'd12, 4'd6, 4'd3, 4'd9};
  localparam logic [COILS_W-1:0] HALF_TAB [0:7] =
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1, 4'd9, 4'd8};

  // Pattern for a phase index in the selected table.
  function automatic logic [COILS_W-1:0] pattern_lookup(input logic half_mode,
                                                        input logic [PHASE_W-1:0] idx);
    logic [COILS_W-1:0] pat;
    if (half_mode) begin
      pat = HALF_TAB[idx];
    end else begin
      pat = FULL_TAB[idx[1:0]];
    end
    return pat;
  endfunction

endpackage

### rtl/sps_cmd_if.sv
// Command channel interface of the stepper phase sequencer.
interface sps_cmd_if;
  import sps_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic                direction;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, command, direction, amount, input ready);
  modport sink   (input valid, command, direction, amount, output ready);
endinterface

### rtl/sps_res_if.sv
// Result channel interface of the stepper phase sequencer.
interface sps_res_if;
  import sps_pkg::*;

  logic               valid;
  logic               ready;
  logic [COILS_W-1:0] coils;
  logic               busy_res;
  logic               accepted;
  logic               done_res;

  modport source (output valid, coils, busy_res, accepted, done_res, input ready);
  modport sink   (input valid, coils, busy_res, accepted, done_res, output ready);
endinterface

### rtl/sps_cfg_if.sv
// Configuration write channel interface of the stepper phase sequencer.
interface sps_cfg_if;
  import sps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sps_deg_conv.sv
// Degrees to step count conversion by reciprocal multiplication, saturating at 65535.
module sps_deg_conv (
  input  logic                         half_mode,
  input  logic [sps_pkg::AMOUNT_W-1:0] degrees,
  output logic [sps_pkg::AMOUNT_W-1:0] count
);
  import sps_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP_FULL_C = RECIP_W'(RECIP_FULL);
  localparam logic [RECIP_W-1:0] RECIP_HALF_C = RECIP_W'(RECIP_HALF);

  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  quot;
  logic               sat;

  // The half-step table doubles the steps per revolution.
  assign recip = half_mode ? RECIP_HALF_C : RECIP_FULL_C;
  assign prod  = PROD_W'(degrees) * PROD_W'(recip);
  assign quot  = prod >> RECIP_SHIFT;

  // Clamp counts that do not fit the count field.
  assign sat   = |quot[PROD_W-1:AMOUNT_W];
  assign count = sat ? '1 : quot[AMOUNT_W-1:0];

endmodule

### rtl/stepper_phase_sequencer.sv
// Top level of the stepper phase sequencer: command handling, phase stepping and result register.
//
//   channel | role   | transaction payload
//   --------+--------+-------------------------------------------
//   cmd     | sink   | command, direction, amount
//   res     | source | coils, busy_res, accepted, done_res
//   cfg     | sink   | index, data (register write)
//
// Each command transaction yields one result transaction;
// a new command is taken every cycle while the result register is empty or being drained.
// The single degrees-to-steps multiplier sits between the command port and the state registers.
// A stalled result holds the command channel off; configuration writes are always taken.
// Synchronous reset clears the coils, the move state and the configuration to defaults.
module stepper_phase_sequencer (
  input  logic      clk,
  input  logic      rst,
  sps_cmd_if.sink   cmd,
  sps_res_if.source res,
  sps_cfg_if.sink   cfg
);
  import sps_pkg::*;

  // Configuration registers.
  logic               step_mode;
  logic               invert_drive;
  logic [DELAY_W-1:0] phase_delay;

  // Move state.
  logic [COILS_W-1:0]  coil_pattern, coil_pattern_next;
  logic [PHASE_W-1:0]  phase_index, phase_index_next;
  logic [AMOUNT_W-1:0] passes_left, passes_left_next;
  logic [DELAY_W-1:0]  hold_count, hold_count_next;
  logic                moving, moving_next;
  logic                latched_direction, latched_direction_next;

  // Result register.
  logic               res_valid;
  logic [COILS_W-1:0] res_coils;
  logic               res_busy;
  logic               res_accepted;
  logic               res_done;

  logic                cmd_fire;
  logic                is_move;
  logic [AMOUNT_W-1:0] deg_count;
  logic [AMOUNT_W-1:0] move_count;
  logic [DELAY_W-1:0]  eff_delay;
  logic [PHASE_W-1:0]  idx_mask;
  logic [PHASE_W-1:0]  start_idx;
  logic [DELAY_W-1:0]  hold_dec;
  logic [PHASE_W-1:0]  cur_idx;
  logic [PHASE_W-1:0]  step_idx;
  logic                wrap;
  logic [AMOUNT_W-1:0] passes_dec;
  logic                acc;
  logic                done;

  // Handshakes.
  assign cmd.ready = !res_valid || res.ready;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign cfg.ready = 1'b1;

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_mode    <= STEP_MODE_RST;
      invert_drive <= INVERT_DRIVE_RST;
      phase_delay  <= PHASE_DELAY_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_STEP_MODE:    step_mode    <= cfg.data[0];
        REG_INVERT_DRIVE: invert_drive <= cfg.data[0];
        REG_PHASE_DELAY:  phase_delay  <= cfg.data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Degrees to steps.
  sps_deg_conv u_deg_conv (
    .half_mode (step_mode),
    .degrees   (cmd.amount),
    .count     (deg_count)
  );

  // Decoded command and derived quantities.
  assign is_move    = (cmd.command == CMD_MOVE_COUNT) || (cmd.command == CMD_MOVE_DEG);
  assign move_count = (cmd.command == CMD_MOVE_DEG) ? deg_count : cmd.amount;
  assign eff_delay  = (phase_delay == '0) ? DELAY_W'(1) : phase_delay;
  assign idx_mask   = step_mode ? 3'd7 : 3'd3;
  assign start_idx  = cmd.direction ? idx_mask : '0;
  assign hold_dec   = (hold_count == '0) ? '0 : hold_count - DELAY_W'(1);
  assign cur_idx    = phase_index & idx_mask;
  assign wrap       = latched_direction ? (cur_idx == '0) : (cur_idx == idx_mask);
  assign step_idx   = (latched_direction ? cur_idx - PHASE_W'(1) : cur_idx + PHASE_W'(1))
                      & idx_mask;
  assign passes_dec = (wrap && passes_left != '0) ? passes_left - AMOUNT_W'(1) : passes_left;

  // Next state for one command transaction.
  always_comb begin
    coil_pattern_next      = coil_pattern;
    phase_index_next       = phase_index;
    passes_left_next       = passes_left;
    hold_count_next        = hold_count;
    moving_next            = moving;
    latched_direction_next = latched_direction;
    acc                    = 1'b0;
    done                   = 1'b0;
    if (cmd_fire) begin
      if (is_move) begin
        // A move is taken only when idle; a zero count starts nothing.
        if (!moving) begin
          acc = 1'b1;
          if (move_count != '0) begin
            latched_direction_next = cmd.direction;
            passes_left_next       = move_count;
            phase_index_next       = start_idx;
            coil_pattern_next      = pattern_lookup(step_mode, start_idx);
            hold_count_next        = eff_delay;
            moving_next            = 1'b1;
          end
        end
      end else if (moving) begin
        // Time tick: count down the hold, then advance or finish.
        hold_count_next = hold_dec;
        if (hold_dec == '0) begin
          passes_left_next = passes_dec;
          if (wrap && passes_dec == '0) begin
            moving_next = 1'b0;
            done        = 1'b1;
          end else begin
            phase_index_next  = step_idx;
            coil_pattern_next = pattern_lookup(step_mode, step_idx);
            hold_count_next   = eff_delay;
          end
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coil_pattern      <= '0;
      phase_index       <= '0;
      passes_left       <= '0;
      hold_count        <= '0;
      moving            <= 1'b0;
      latched_direction <= 1'b0;
    end else begin
      coil_pattern      <= coil_pattern_next;
      phase_index       <= phase_index_next;
      passes_left       <= passes_left_next;
      hold_count        <= hold_count_next;
      moving            <= moving_next;
      latched_direction <= latched_direction_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_fire) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload, loaded with each command transaction.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      res_coils    <= coil_pattern_next ^ {COILS_W{invert_drive}};
      res_busy     <= moving_next;
      res_accepted <= acc;
      res_done     <= done;
    end
  end

  assign res.valid    = res_valid;
  assign res.coils    = res_coils;
  assign res.busy_res = res_busy;
  assign res.accepted = res_accepted;
  assign res.done_res = res_done;

`ifndef ASSERT_OFF
  // A move in progress always has a pattern hold running.
  a_hold_nonzero: assert property (@(posedge clk) disable iff (rst)
    moving |-> hold_count != '0)
    else $error("hold count is zero during a move");

  // A move in progress always has passes left to play.
  a_passes_nonzero: assert property (@(posedge clk) disable iff (rst)
    moving |-> passes_left != '0)
    else $error("no passes left during a move");

  // A move only starts from a command transaction.
  a_move_start: assert property (@(posedge clk) disable iff (rst)
    $rose(moving) |-> $past(cmd.valid && cmd.ready))
    else $error("move started without a command transaction");

  // A finished move leaves the block idle and was not a new command.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_done) |-> (!res_busy && !res_accepted))
    else $error("done reported with busy or accepted set");
`endif

endmodule

### dv/stepper_phase_sequencer_checker.sv
// Checker for the stepper phase sequencer: predicts every drive result and compares it.
module stepper_phase_sequencer_checker
  import sps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sps_cmd_if   cmd,
  sps_res_if   res,
  sps_cfg_if   cfg,
  output int   mismatch_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REV_STEPS    = 200;
  localparam int DEG_PER_TURN = 360;

  // Coil sequences for the two stepping modes.
  localparam logic [COILS_W-1:0] FOUR_PHASE_SEQ [4] = '{4'd12, 4'd6, 4'd3, 4'd9};
  localparam logic [COILS_W-1:0] EIGHT_PHASE_SEQ [8] =
    '{4'd12, 4'd4, 4'd6, 4'd2, 4'd3, 4'd1, 4'd9, 4'd8};

  typedef struct packed {
    logic [COILS_W-1:0] coils;
    logic               busy;
    logic               accepted;
    logic               done;
  } drive_outcome_t;

  // Register copies.
  logic               eight_phase;
  logic               invert_out;
  logic [DELAY_W-1:0] hold_ticks;

  // Motor state.
  logic [COILS_W-1:0] pattern;
  logic [PHASE_W-1:0] phase;
  logic [15:0]        passes;
  logic [DELAY_W-1:0] hold_left;
  logic               running;
  logic               reverse;

  drive_outcome_t drive_outcomes_q [$];

  function automatic logic [COILS_W-1:0] coil_entry(input logic [PHASE_W-1:0] i);
    if (eight_phase) begin
      return EIGHT_PHASE_SEQ[i];
    end
    return FOUR_PHASE_SEQ[i[1:0]];
  endfunction

  function automatic logic [DELAY_W-1:0] eff_hold();
    return (hold_ticks == '0) ? DELAY_W'(1) : hold_ticks;
  endfunction

  // Apply one command transaction to the motor state and return what the block reports.
  function automatic drive_outcome_t advance_motor(input cmd_t code, input logic dir,
                                                   input logic [AMOUNT_W-1:0] amt);
    drive_outcome_t     pred;
    logic [31:0]        steps;
    logic [PHASE_W-1:0] last;
    logic [PHASE_W-1:0] cur;
    logic               wrap;
    pred = '0;
    last = eight_phase ? PHASE_W'(7) : PHASE_W'(3);
    if (code == CMD_MOVE_COUNT || code == CMD_MOVE_DEG) begin
      // A move is only taken while the motor stands still.
      if (!running) begin
        pred.accepted = 1'b1;
        steps = 32'(amt);
        if (code == CMD_MOVE_DEG) begin
          steps = (32'(amt) * (eight_phase ? 32'(2 * REV_STEPS) : 32'(REV_STEPS)))
                  / 32'(DEG_PER_TURN);
          if (steps > 32'd65535) begin
            steps = 32'd65535;
          end
        end
        if (steps != 0) begin
          reverse   = dir;
          passes    = steps[15:0];
          phase     = dir ? last : '0;
          pattern   = coil_entry(phase);
          hold_left = eff_hold();
          running   = 1'b1;
        end
      end
    end else if (running) begin
      // Time tick: count down the hold, then step to the next pattern or finish the move.
      if (hold_left != 0) begin
        hold_left--;
      end
      if (hold_left == 0) begin
        cur  = phase & last;
        wrap = reverse ? (cur == '0) : (cur == last);
        if (wrap && passes != 0) begin
          passes--;
        end
        if (wrap && passes == 0) begin
          running   = 1'b0;
          pred.done = 1'b1;
        end else begin
          phase     = reverse ? ((cur - 1'b1) & last) : ((cur + 1'b1) & last);
          pattern   = coil_entry(phase);
          hold_left = eff_hold();
        end
      end
    end
    pred.coils = pattern ^ {COILS_W{invert_out}};
    pred.busy  = running;
    return pred;
  endfunction

  // Watch all three channels; results are compared before new commands are queued.
  always @(posedge clk) begin
    drive_outcome_t seen;
    drive_outcome_t want;
    if (rst) begin
      eight_phase = 1'b0;
      invert_out  = 1'b0;
      hold_ticks  = 16'd10;
      pattern     = '0;
      phase       = '0;
      passes      = '0;
      hold_left   = '0;
      running     = 1'b0;
      reverse     = 1'b0;
      drive_outcomes_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        seen = {res.coils, res.busy_res, res.accepted, res.done_res};
        if (drive_outcomes_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result transaction with nothing expected: %s",
                     $time, "see values below");
            $display("  coils %h busy %b acc %b done %b",
                     seen.coils, seen.busy, seen.accepted, seen.done);
          end
        end else begin
          want = drive_outcomes_q.pop_front();
          if (seen.coils !== want.coils || seen.busy !== want.busy ||
              seen.accepted !== want.accepted || seen.done !== want.done) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: coils exp %h got %h, busy exp %b got %b,",
                       $time, want.coils, seen.coils, want.busy, seen.busy);
              $display("  acc exp %b got %b, done exp %b got %b",
                       want.accepted, seen.accepted, want.done, seen.done);
            end
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_reg_t'(cfg.index))
          REG_STEP_MODE:    eight_phase = cfg.data[0];
          REG_INVERT_DRIVE: invert_out  = cfg.data[0];
          REG_PHASE_DELAY:  hold_ticks  = cfg.data;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        drive_outcomes_q.push_back(advance_motor(cmd_t'(cmd.command), cmd.direction,
                                                 cmd.amount));
      end
    end
    outstanding = drive_outcomes_q.size();
  end

endmodule

### dv/stepper_phase_sequencer_tb.sv
// Testbench top for the stepper phase sequencer: clock, reset, stimulus and verdict.
module stepper_phase_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          STALL_LEN   = 300;

  logic        clk = 1'b0;
  logic        rst;
  int          mismatch_count;
  int          outstanding;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_req;
  int          stall_seen;
  int          stall_left;
  int unsigned cycles;
  int unsigned ticks_owed;
  logic        half_cfg;
  logic [15:0] delay_cfg;

  sps_cmd_if cmd_ch ();
  sps_res_if res_ch ();
  sps_cfg_if cfg_ch ();

  stepper_phase_sequencer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  stepper_phase_sequencer_checker coil_check (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .res            (res_ch),
    .cfg            (cfg_ch),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always #10 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("stepper_phase_sequencer: mismatch");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        stall_left = STALL_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic cmd_t tick_code();
    return ($urandom_range(3) == 0) ? CMD_TICK_ALT : CMD_TICK;
  endfunction

  // One command transaction, preceded by random idle cycles.
  task automatic send_cmd(input cmd_t code, input logic dir, input logic [AMOUNT_W-1:0] amt);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= code;
    cmd_ch.direction <= dir;
    cmd_ch.amount    <= amt;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic tick_out(input int unsigned n);
    repeat (n) send_cmd(tick_code(), 1'($urandom_range(1)), 16'($urandom));
  endtask

  // Stop sending until every expected result has come back.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Finish any move in flight, then program all three registers.
  task automatic configure(input logic half, input logic inv, input logic [15:0] dly);
    tick_out(ticks_owed);
    ticks_owed = 0;
    drain_results();
    write_reg(REG_STEP_MODE, 16'(half));
    write_reg(REG_INVERT_DRIVE, 16'(inv));
    write_reg(REG_PHASE_DELAY, dly);
    half_cfg  = half;
    delay_cfg = dly;
  endtask

  task automatic random_setting();
    logic [15:0] dly;
    dly = ($urandom_range(9) < 2) ? 16'($urandom_range(16, 5)) : 16'($urandom_range(4));
    configure(1'($urandom_range(1)), 1'($urandom_range(1)), dly);
  endtask

  // Mostly complete moves with random content; some idle ticks and moves while busy.
  task automatic run_random(input int n);
    int unsigned         r;
    int unsigned         passes;
    cmd_t                code;
    logic [AMOUNT_W-1:0] amt;
    repeat (n) begin
      r = $urandom_range(99);
      if (ticks_owed == 0 && r < 70) begin
        code = ($urandom_range(1) == 1) ? CMD_MOVE_DEG : CMD_MOVE_COUNT;
        if (code == CMD_MOVE_DEG) begin
          amt    = 16'($urandom_range(half_cfg ? 3 : 6));
          passes = (int'(amt) * (half_cfg ? 400 : 200)) / 360;
        end else begin
          amt    = 16'($urandom_range(3));
          passes = amt;
        end
        ticks_owed = passes * (half_cfg ? 8 : 4) * ((delay_cfg == 0) ? 1 : delay_cfg);
        send_cmd(code, 1'($urandom_range(1)), amt);
      end else if (ticks_owed != 0 && r < 8) begin
        code = ($urandom_range(1) == 1) ? CMD_MOVE_DEG : CMD_MOVE_COUNT;
        send_cmd(code, 1'($urandom_range(1)), 16'($urandom));
      end else begin
        send_cmd(tick_code(), 1'($urandom_range(1)), 16'($urandom));
        if (ticks_owed != 0) begin
          ticks_owed--;
        end
      end
    end
  endtask

  task automatic run_profile(input int s_pct, input int r_pct, input bit with_stall);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (4) begin
      random_setting();
      if (with_stall) begin
        stall_req++;
        with_stall = 1'b0;
      end
      run_random(40);
    end
  endtask

  // Main stimulus.
  initial begin
    rst              <= 1'b1;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.command   <= CMD_TICK;
    cmd_ch.direction <= 1'b0;
    cmd_ch.amount    <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_STEP_MODE;
    cfg_ch.data      <= '0;
    ticks_owed = 0;
    half_cfg   = 1'b0;
    delay_cfg  = 16'd10;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Idle ticks and zero-length moves with the reset settings.
    send_cmd(CMD_TICK, 1'b0, 16'hFFFF);
    send_cmd(CMD_TICK_ALT, 1'b1, 16'h0000);
    send_cmd(CMD_MOVE_COUNT, 1'b0, 16'd0);
    send_cmd(CMD_MOVE_DEG, 1'b1, 16'd1);

    // One pass at the reset delay, with the delay lowered part way through.
    send_cmd(CMD_MOVE_COUNT, 1'b0, 16'd1);
    send_cmd(CMD_MOVE_DEG, 1'b1, 16'hFFFF);
    send_cmd(CMD_TICK_ALT, 1'b0, 16'h5A5A);
    drain_results();
    write_reg(REG_PHASE_DELAY, 16'd1);
    tick_out(13);

    // Half-step reverse pass, switched to full-step while moving.
    configure(1'b1, 1'b1, 16'd1);
    send_cmd(CMD_MOVE_DEG, 1'b1, 16'd1);
    tick_out(2);
    drain_results();
    write_reg(REG_STEP_MODE, 16'd0);
    tick_out(3);

    // Random phases: sender lightly idle, then receiver lightly idle, then no idling.
    run_profile(12, 65, 1'b1);
    run_profile(65, 12, 1'b0);
    run_profile(0, 0, 1'b1);

    // Largest angle saturates the pass count under the longest hold; the move is left running
    // after the mode and the delay are changed under it.
    configure(1'b1, 1'b1, 16'hFFFF);
    send_cmd(CMD_MOVE_DEG, 1'b0, 16'hFFFF);
    tick_out(5);
    drain_results();
    write_reg(REG_STEP_MODE, 16'd0);
    write_reg(REG_PHASE_DELAY, 16'd0);
    tick_out(5);

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("stepper_phase_sequencer: match");
    end else begin
      $display("stepper_phase_sequencer: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sps_pkg.sv
rtl/sps_cmd_if.sv
rtl/sps_res_if.sv
rtl/sps_cfg_if.sv
rtl/sps_deg_conv.sv
rtl/stepper_phase_sequencer.sv
dv/stepper_phase_sequencer_checker.sv
dv/stepper_phase_sequencer_tb.sv
